@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file mips32_ex_chk.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

`endif

@@ rtl/mips32_ex_pkg.sv @@
// Opcode, function and constant definitions for the MIPS32 execute block.
// No dependencies.
`default_nettype none

package mips32_ex_pkg;

  localparam logic [31:0] TEXT_START     = 32'h0040_0000;
  localparam int unsigned DMEM_WORDS_DEF = 1024;
  localparam logic [31:0] V0_EXIT        = 32'd10;
  localparam logic [4:0]  REG_V0         = 5'd2;
  localparam logic [4:0]  REG_RA         = 5'd31;

  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6;
  localparam logic [5:0] OP_BGTZ    = 6'd7;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_ADDIU   = 6'd9;
  localparam logic [5:0] OP_SLTI    = 6'd10;
  localparam logic [5:0] OP_SLTIU   = 6'd11;
  localparam logic [5:0] OP_ANDI    = 6'd12;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_XORI    = 6'd14;
  localparam logic [5:0] OP_LUI     = 6'd15;
  localparam logic [5:0] OP_LB      = 6'd32;
  localparam logic [5:0] OP_LH      = 6'd33;
  localparam logic [5:0] OP_LW      = 6'd35;
  localparam logic [5:0] OP_LBU     = 6'd36;
  localparam logic [5:0] OP_LHU     = 6'd37;
  localparam logic [5:0] OP_SB      = 6'd40;
  localparam logic [5:0] OP_SH      = 6'd41;
  localparam logic [5:0] OP_SW      = 6'd43;

  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1A;
  localparam logic [5:0] FN_DIVU    = 6'h1B;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2A;
  localparam logic [5:0] FN_SLTU    = 6'h2B;

  localparam logic [4:0] RT_BLTZ    = 5'd0;
  localparam logic [4:0] RT_BGEZ    = 5'd1;
  localparam logic [4:0] RT_BLTZAL  = 5'd16;
  localparam logic [4:0] RT_BGEZAL  = 5'd17;

  function automatic logic is_mem_op(input logic [5:0] op);
    return (op == OP_LB) || (op == OP_LH) || (op == OP_LW) || (op == OP_LBU) ||
           (op == OP_LHU) || (op == OP_SB) || (op == OP_SH) || (op == OP_SW);
  endfunction

endpackage

`default_nettype wire

@@ rtl/mips32_instruction_execute.sv @@
// MIPS32 integer execute block: register file and data memory in on-chip RAM.
// Uses mips32_ex_pkg.
//
// Usage:
// - Input channel: instruction_word_i with in_valid_i / in_stall_o. Feed the
//   word fetched at the next_pc_o of the previous result (0x00400000 first).
// - Output channel: one result per instruction on out_valid_o / out_stall_i,
//   held in an output register; a stalled result keeps its value.
// - An instruction is taken only while the core is idle. Its result is
//   written to the output register at commit: ALU, branch and jump ops
//   commit from decode; loads and stores first pass the data RAM read (and
//   the address reduction when DATA_MEM_WORDS is not a power of two),
//   multiplies the product register, nonzero divides the radix-2 divider.
// - One instruction is in flight at a time: the register file RAM read and
//   the execute/write-back step finish before the next one is taken.
// - The next instruction may be taken while a result waits on out_stall_i;
//   its write-back then waits until the output register is free.
// - After reset the data RAM is cleared one word per cycle, all DATA_MEM_WORDS
//   words, with in_stall_o high. Registers, HI, LO reset to zero.
// - After a halting syscall every instruction returns the halted pc only.
`default_nettype none

module mips32_instruction_execute
  import mips32_ex_pkg::*;
#(
  parameter int unsigned DATA_MEM_WORDS = DMEM_WORDS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] instruction_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      next_pc_o,
  output logic             reg_write_o,
  output logic [4:0]       reg_index_o,
  output logic [31:0]      reg_value_o,
  output logic             mem_write_o,
  output logic [31:0]      mem_address_o,
  output logic [31:0]      mem_store_data_o,
  output logic [3:0]       mem_byte_enable_o,
  output logic [31:0]      hi_value_o,
  output logic [31:0]      lo_value_o,
  output logic             halted_o
);

  localparam int unsigned AW   = $clog2(DATA_MEM_WORDS);
  localparam bit          POW2 = (DATA_MEM_WORDS & (DATA_MEM_WORDS - 1)) == 0;
  localparam logic [AW:0]   DM_N     = (AW + 1)'(DATA_MEM_WORDS);
  localparam logic [AW-1:0] DM_LAST  = AW'(DATA_MEM_WORDS - 1);
  localparam logic [31:0]   DM_N32   = 32'(DATA_MEM_WORDS);
  localparam logic [31:0]   DM_RECIP = 32'((64'd1 << 32) / DATA_MEM_WORDS);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DEC   = 3'd2;
  localparam logic [2:0] ST_MOD   = 3'd3;
  localparam logic [2:0] ST_MEM   = 3'd4;
  localparam logic [2:0] ST_MUL   = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_DIVW  = 3'd7;

  logic [31:0] rf_mem [32];
  logic [31:0] dmem [DATA_MEM_WORDS];

  logic [2:0]    state_q, state_d;
  logic [31:0]   pc_q, hi_q, lo_q, v0_q;
  logic          halt_q;
  logic [31:0]   rf_vld_q;
  logic [AW-1:0] clr_q;
  logic [31:0]   ir_q, rf_a_q, rf_b_q, dm_rdata_q;
  logic [AW-1:0] dm_idx_q;
  logic [63:0]   prod_q;
  logic [31:0]   dq_q, drem_q, dvs_q;
  logic          dneg_q, rneg_q;
  logic [4:0]    dcnt_q, mcnt_q;
  logic [29:0]   mx_q, mq_q;
  logic [AW:0]   mr_q;

  logic          out_valid_q;
  logic [31:0]   npc_q, wval_q, addr_q, sdata_q, hio_q, loo_q;
  logic          wr_q, st_q, halto_q;
  logic [4:0]    widx_q;
  logic [3:0]    be_q;

  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sa;
  logic [31:0] a, b, simm, imm, addr, btgt;
  assign op   = ir_q[31:26];
  assign rs   = ir_q[25:21];
  assign rt   = ir_q[20:16];
  assign rd   = ir_q[15:11];
  assign sa   = ir_q[10:6];
  assign fn   = ir_q[5:0];
  assign imm  = {16'b0, ir_q[15:0]};
  assign simm = {{16{ir_q[15]}}, ir_q[15:0]};
  assign a    = (rs != 5'd0 && rf_vld_q[rs]) ? rf_a_q : 32'd0;
  assign b    = (rt != 5'd0 && rf_vld_q[rt]) ? rf_b_q : 32'd0;
  assign addr = a + simm;
  assign btgt = pc_q + 32'd4 + {simm[29:0], 2'b00};

  logic accept, out_free, commit, go_long, is_div, is_muldiv, msgn;
  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign is_div   = (op == OP_SPECIAL) && (fn == FN_DIV || fn == FN_DIVU) && (b != 32'd0);
  assign is_muldiv = is_div || ((op == OP_SPECIAL) && (fn == FN_MULT || fn == FN_MULTU));
  assign go_long  = !halt_q && (is_mem_op(op) || is_muldiv);
  assign commit   = out_free && ((state_q == ST_DEC && !go_long) || state_q == ST_MEM ||
                                 state_q == ST_MUL || state_q == ST_DIVW);
  assign msgn     = (fn == FN_MULT) || (fn == FN_DIV);

  logic signed [65:0] mul_full;
  assign mul_full = $signed({msgn & a[31], a}) * $signed({msgn & b[31], b});

  logic [32:0] dr2;
  logic        dge;
  assign dr2 = {drem_q, dq_q[31]};
  assign dge = dr2 >= {1'b0, dvs_q};

  // Word index reduction: reciprocal estimate, remainder, one correction.
  logic [61:0]   mprod;
  logic [31:0]   mqn;
  logic [AW-1:0] mrem_n;
  assign mprod  = mx_q * DM_RECIP;
  assign mqn    = {2'b00, mq_q} * DM_N32;
  assign mrem_n = (mr_q >= DM_N) ? AW'(mr_q - DM_N) : mr_q[AW-1:0];

  logic [31:0] q_fix, r_fix;
  assign q_fix = dneg_q ? 32'd0 - dq_q : dq_q;
  assign r_fix = rneg_q ? 32'd0 - drem_q : drem_q;

  // Execute and write-back values.
  logic [31:0] c_npc, c_wval, c_sdata, c_hi, c_lo, c_merge, bmask;
  logic [31:0] lb_w, lh_w;
  logic [4:0]  c_widx;
  logic        c_wr, c_mem, c_st, c_halt;
  logic [3:0]  c_be;

  assign lb_w = dm_rdata_q >> {addr[1:0], 3'b000};
  assign lh_w = dm_rdata_q >> {addr[1], 4'b0000};

  always_comb begin
    c_npc   = pc_q + 32'd4;
    c_wr    = 1'b0;
    c_widx  = 5'd0;
    c_wval  = 32'd0;
    c_mem   = 1'b0;
    c_st    = 1'b0;
    c_sdata = 32'd0;
    c_be    = 4'd0;
    c_hi    = hi_q;
    c_lo    = lo_q;
    c_halt  = halt_q;
    if (halt_q) begin
      c_npc = pc_q;
    end else if (op == OP_SPECIAL) begin
      c_widx = rd;
      c_wr   = 1'b1;
      unique case (fn)
        FN_ADD, FN_ADDU: c_wval = a + b;
        FN_SUB, FN_SUBU: c_wval = a - b;
        FN_AND:  c_wval = a & b;
        FN_OR:   c_wval = a | b;
        FN_XOR:  c_wval = a ^ b;
        FN_NOR:  c_wval = ~(a | b);
        FN_SLT:  c_wval = {31'd0, $signed(a) < $signed(b)};
        FN_SLTU: c_wval = {31'd0, a < b};
        FN_SLL:  c_wval = b << sa;
        FN_SRL:  c_wval = b >> sa;
        FN_SRA:  c_wval = $signed(b) >>> sa;
        FN_SLLV: c_wval = b << a[4:0];
        FN_SRLV: c_wval = b >> a[4:0];
        FN_SRAV: c_wval = $signed(b) >>> a[4:0];
        FN_MFHI: c_wval = hi_q;
        FN_MFLO: c_wval = lo_q;
        FN_JR: begin
          c_wr  = 1'b0;
          c_npc = a;
        end
        FN_JALR: begin
          c_wval = pc_q + 32'd4;
          c_npc  = a;
        end
        FN_MTHI: begin
          c_wr = 1'b0;
          c_hi = a;
        end
        FN_MTLO: begin
          c_wr = 1'b0;
          c_lo = a;
        end
        FN_MULT, FN_MULTU: begin
          c_wr = 1'b0;
          c_hi = prod_q[63:32];
          c_lo = prod_q[31:0];
        end
        FN_DIV, FN_DIVU: begin
          c_wr = 1'b0;
          if (b == 32'd0) begin
            c_hi = a;
            c_lo = 32'hFFFF_FFFF;
          end else begin
            c_hi = r_fix;
            c_lo = q_fix;
          end
        end
        FN_SYSCALL: begin
          c_wr = 1'b0;
          if (v0_q == V0_EXIT) c_halt = 1'b1;
        end
        default: c_wr = 1'b0;
      endcase
    end else if (op == OP_J || op == OP_JAL) begin
      c_npc = {pc_q[31:28], ir_q[25:0], 2'b00};
      if (op == OP_JAL) begin
        c_wr   = 1'b1;
        c_widx = REG_RA;
        c_wval = pc_q + 32'd4;
      end
    end else begin
      c_widx = rt;
      unique case (op)
        OP_ADDI, OP_ADDIU: begin c_wr = 1'b1; c_wval = a + simm; end
        OP_SLTI:  begin c_wr = 1'b1; c_wval = {31'd0, $signed(a) < $signed(simm)}; end
        OP_SLTIU: begin c_wr = 1'b1; c_wval = {31'd0, a < simm}; end
        OP_ANDI:  begin c_wr = 1'b1; c_wval = a & imm; end
        OP_ORI:   begin c_wr = 1'b1; c_wval = a | imm; end
        OP_XORI:  begin c_wr = 1'b1; c_wval = a ^ imm; end
        OP_LUI:   begin c_wr = 1'b1; c_wval = {ir_q[15:0], 16'd0}; end
        OP_BEQ:   if (a == b) c_npc = btgt;
        OP_BNE:   if (a != b) c_npc = btgt;
        OP_BLEZ:  if (a == 32'd0 || a[31]) c_npc = btgt;
        OP_BGTZ:  if (a != 32'd0 && !a[31]) c_npc = btgt;
        OP_REGIMM: begin
          if (rt == RT_BLTZ || rt == RT_BLTZAL) begin
            if (a[31]) c_npc = btgt;
          end else if (rt == RT_BGEZ || rt == RT_BGEZAL) begin
            if (!a[31]) c_npc = btgt;
          end
          if (rt == RT_BLTZAL || rt == RT_BGEZAL) begin
            c_wr   = 1'b1;
            c_widx = REG_RA;
            c_wval = pc_q + 32'd4;
          end
        end
        OP_LW:  begin c_mem = 1'b1; c_wr = 1'b1; c_wval = dm_rdata_q; end
        OP_LB:  begin c_mem = 1'b1; c_wr = 1'b1; c_wval = {{24{lb_w[7]}}, lb_w[7:0]}; end
        OP_LBU: begin c_mem = 1'b1; c_wr = 1'b1; c_wval = {24'd0, lb_w[7:0]}; end
        OP_LH:  begin c_mem = 1'b1; c_wr = 1'b1; c_wval = {{16{lh_w[15]}}, lh_w[15:0]}; end
        OP_LHU: begin c_mem = 1'b1; c_wr = 1'b1; c_wval = {16'd0, lh_w[15:0]}; end
        OP_SW: begin
          c_mem = 1'b1; c_st = 1'b1; c_be = 4'hF; c_sdata = b;
        end
        OP_SB: begin
          c_mem = 1'b1; c_st = 1'b1;
          c_be    = 4'b0001 << addr[1:0];
          c_sdata = {24'd0, b[7:0]} << {addr[1:0], 3'b000};
        end
        OP_SH: begin
          c_mem = 1'b1; c_st = 1'b1;
          c_be    = 4'b0011 << {addr[1], 1'b0};
          c_sdata = {16'd0, b[15:0]} << {addr[1], 4'b0000};
        end
        default: c_wr = 1'b0;
      endcase
    end
    if (c_widx == 5'd0) c_wr = 1'b0;
    if (!c_wr) begin
      c_widx = 5'd0;
      c_wval = 32'd0;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) bmask[i*8 +: 8] = {8{c_be[i]}};
    c_merge = (dm_rdata_q & ~bmask) | (c_sdata & bmask);
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == DM_LAST) state_d = ST_IDLE;
      ST_IDLE:  if (accept) state_d = ST_DEC;
      ST_DEC: begin
        if (go_long) begin
          if (is_mem_op(op)) state_d = POW2 ? ST_MEM : ST_MOD;
          else if (is_div)   state_d = ST_DIV;
          else               state_d = ST_MUL;
        end else if (commit) begin
          state_d = ST_IDLE;
        end
      end
      ST_MOD:  if (mcnt_q == 5'd0) state_d = ST_MEM;
      ST_DIV:  if (dcnt_q == 5'd0) state_d = ST_DIVW;
      ST_MEM, ST_MUL, ST_DIVW: if (commit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      pc_q        <= TEXT_START;
      hi_q        <= 32'd0;
      lo_q        <= 32'd0;
      v0_q        <= 32'd0;
      halt_q      <= 1'b0;
      rf_vld_q    <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
      if (commit) begin
        pc_q     <= c_npc;
        hi_q     <= c_hi;
        lo_q     <= c_lo;
        halt_q   <= c_halt;
        if (c_wr) rf_vld_q[c_widx] <= 1'b1;
        if (c_wr && c_widx == REG_V0) v0_q <= c_wval;
      end
      if (commit)           out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ir_q   <= instruction_word_i;
      rf_a_q <= rf_mem[instruction_word_i[25:21]];
      rf_b_q <= rf_mem[instruction_word_i[20:16]];
    end
    if (commit && c_wr) rf_mem[c_widx] <= c_wval;
    if (state_q == ST_DEC) begin
      prod_q <= mul_full[63:0];
      dq_q   <= (msgn && a[31]) ? 32'd0 - a : a;
      dvs_q  <= (msgn && b[31]) ? 32'd0 - b : b;
      dneg_q <= msgn && (a[31] ^ b[31]);
      rneg_q <= msgn && a[31];
      drem_q <= 32'd0;
      dcnt_q <= 5'd31;
      mx_q   <= addr[31:2];
      mcnt_q <= 5'd2;
    end
    if (state_q == ST_DIV) begin
      drem_q <= dge ? 32'(dr2 - {1'b0, dvs_q}) : dr2[31:0];
      dq_q   <= {dq_q[30:0], dge};
      dcnt_q <= dcnt_q - 5'd1;
    end
    if (state_q == ST_MOD) begin
      if (mcnt_q == 5'd2) mq_q <= mprod[61:32];
      if (mcnt_q == 5'd1) mr_q <= (AW + 1)'({2'b00, mx_q} - mqn);
      mcnt_q <= mcnt_q - 5'd1;
    end
    if (commit) begin
      npc_q   <= c_npc;
      wr_q    <= c_wr;
      widx_q  <= c_widx;
      wval_q  <= c_wval;
      st_q    <= c_st;
      addr_q  <= c_mem ? addr : 32'd0;
      sdata_q <= c_sdata;
      be_q    <= c_be;
      hio_q   <= c_hi;
      loo_q   <= c_lo;
      halto_q <= c_halt;
    end
  end

  // Data RAM: one read port, one write port.
  logic          dm_rd;
  logic [AW-1:0] dm_ridx;
  always_comb begin
    dm_rd   = 1'b0;
    dm_ridx = addr[AW+1:2];
    if (state_q == ST_DEC && go_long && is_mem_op(op) && POW2) dm_rd = 1'b1;
    if (state_q == ST_MOD && mcnt_q == 5'd0) begin
      dm_rd   = 1'b1;
      dm_ridx = mrem_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dm_rd) begin
      dm_rdata_q <= dmem[dm_ridx];
      dm_idx_q   <= dm_ridx;
    end
    if (state_q == ST_CLEAR) dmem[clr_q] <= 32'd0;
    else if (commit && c_st) dmem[dm_idx_q] <= c_merge;
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign next_pc_o         = npc_q;
  assign reg_write_o       = wr_q;
  assign reg_index_o       = widx_q;
  assign reg_value_o       = wval_q;
  assign mem_write_o       = st_q;
  assign mem_address_o     = addr_q;
  assign mem_store_data_o  = sdata_q;
  assign mem_byte_enable_o = be_q;
  assign hi_value_o        = hio_q;
  assign lo_value_o        = loo_q;
  assign halted_o          = halto_q;

endmodule

`default_nettype wire

@@ rtl/mips32_ex_chk.sv @@
// Port-level checker for mips32_instruction_execute, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mips32_ex_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] next_pc_o,
  input wire logic        reg_write_o,
  input wire logic [4:0]  reg_index_o,
  input wire logic        mem_write_o,
  input wire logic [3:0]  mem_byte_enable_o,
  input wire logic        halted_o
);

  `CHK_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")
  `CHK_ASSERT(a_pc_stable, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(next_pc_o), "stalled pc changed")
  `CHK_ASSERT(a_new_result_busy, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_stall_o), "result without work")
  `CHK_ASSERT(a_write_kind, clk_i, rst_ni, out_valid_o |-> !(reg_write_o && (mem_write_o || reg_index_o == 5'd0)) && (mem_write_o == (mem_byte_enable_o != 4'd0)) && !(halted_o && (reg_write_o || mem_write_o)), "bad write report")

endmodule

bind mips32_instruction_execute mips32_ex_chk u_chk (.*);

`default_nettype wire
